### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the voice allocator.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent true implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/pva_pkg.sv
// Types and constants of the polyphonic voice allocator.
// No dependencies; imported by polyphonic_voice_allocator and the bench.
package pva_pkg;

	localparam int REQ_W      = 2;
	localparam int NOTE_W     = 7;
	localparam int NOTE_COUNT = 128;
	localparam int CFG_W      = 5;
	localparam int VOICE_W    = 4;

	localparam logic [NOTE_W-1:0] NOTE_LAST = NOTE_W'(NOTE_COUNT - 1);

	// event codes
	localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SUS_ON   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_SUS_OFF  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_STEAL,
		S_EMIT,
		S_SCAN,
		S_SREL,
		S_SPUSH,
		S_SFIN
	} state_t;

endpackage

### hw/rtl/polyphonic_voice_allocator.sv
// Polyphonic voice allocator: top level, one sequencer over the note and voice tables.
// Depends on pva_pkg and assert_macros.svh.
//
// Maps MIDI notes to synth voices. One beat in, zero or more beats out.
// Note on: a note that already owns a voice gets it back; otherwise the voice under a
// round-robin pointer (counting down from voices_in_use-1, wrapping) is taken, any note on
// it is dropped, and the note is marked held. Note off clears held; with sustain off and
// a voice mapped it frees the voice and reports it, else it reports found=0, voice=0.
// Sustain on gives no beat. Sustain off walks all 128 notes in ascending order and frees
// every mapped note that is not held, one beat each, last=1 on the final one; nothing to
// free, no beat. Note on/off go through decode then emit, with a steal step between for a
// note on that needs a new voice; sustain on needs no step beyond idle. The sustain-off
// walk examines one note-map slot per cycle, pausing to free each hit and while a freed
// voice waits on output stall. in_stall is high whenever the sequencer is not idle. The
// note map lives in a 128-entry RAM with registered read plus a valid bit per note in
// flops, so reset needs no clearing pass. cfg_wen/cfg_wdata load voices_in_use (0 reads as
// 1, above MAX_VOICES reads as MAX_VOICES) and reload the pointer; write only while idle.
`include "assert_macros.svh"

module polyphonic_voice_allocator #(
	parameter int MAX_VOICES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pva_pkg::REQ_W-1:0]   req_type,
	input  logic [pva_pkg::NOTE_W-1:0]  note,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pva_pkg::VOICE_W-1:0] voice,
	output logic                        found,
	output logic                        last,
	input  logic                        cfg_wen,
	input  logic [pva_pkg::CFG_W-1:0]   cfg_wdata
);
	import pva_pkg::*;

	localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam logic [CFG_W-1:0] ACTIVE_RST =
		(MAX_VOICES < 16) ? CFG_W'(MAX_VOICES) : CFG_W'(16);

	function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0)
			r = CFG_W'(1);
		else if (int'(v) > MAX_VOICES)
			r = CFG_W'(MAX_VOICES);
		return r;
	endfunction

	state_t state_q, state_d;

	logic                  sustain_q;
	logic [CFG_W-1:0]      active_q;
	logic [VW-1:0]         next_voice_q;
	logic [NOTE_COUNT-1:0] nv_valid_q;
	logic [NOTE_COUNT-1:0] held_q;
	logic [MAX_VOICES-1:0] vn_valid_q;
	logic                  pend_q;
	logic [NOTE_W-1:0]     scan_idx_q;
	logic                  out_valid_q;

	logic [NOTE_W-1:0] note_q;
	logic [REQ_W-1:0]  req_q;
	logic [VW-1:0]     v_q;
	logic [VW-1:0]     cur_q;
	logic [VW-1:0]     res_voice_q;
	logic              res_found_q;
	logic [VOICE_W-1:0] out_voice_q;
	logic              out_found_q;
	logic              out_last_q;

	// note -> voice table and voice -> note table, registered reads
	logic [VW-1:0]     nv_mem [NOTE_COUNT];
	logic [NOTE_W-1:0] vn_mem [MAX_VOICES];
	logic [VW-1:0]     nv_rd_q;
	logic [NOTE_W-1:0] vn_rd_q;
	logic [NOTE_W-1:0] nv_raddr;

	logic          out_free;
	logic          out_load;
	logic [VW-1:0] out_voice_d;
	logic          out_found_d;
	logic          out_last_d;
	logic          accept;
	logic          scan_hit;
	logic          dec_miss;
	logic          off_rel;

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign scan_hit = nv_valid_q[scan_idx_q] && !held_q[scan_idx_q];
	assign dec_miss = (req_q == REQ_NOTE_ON) && !nv_valid_q[note_q];
	assign off_rel  = (req_q == REQ_NOTE_OFF) && !sustain_q && nv_valid_q[note_q];
	// idle: look up the incoming note; scanning: look up the scan slot
	assign nv_raddr = (state_q == S_SCAN) ? scan_idx_q : note;

	assign out_valid = out_valid_q;
	assign voice     = out_voice_q;
	assign found     = out_found_q;
	assign last      = out_last_q;

	// sequencer: next state and output load
	always_comb begin
		state_d     = state_q;
		out_load    = 1'b0;
		out_voice_d = res_voice_q;
		out_found_d = res_found_q;
		out_last_d  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (req_type) inside
						REQ_NOTE_ON, REQ_NOTE_OFF: state_d = S_DEC;
						REQ_SUS_OFF:               state_d = S_SCAN;
						default:                   state_d = S_IDLE;
					endcase
				end
			end
			S_DEC:   state_d = dec_miss ? S_STEAL : S_EMIT;
			S_STEAL: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				if (scan_hit)
					state_d = S_SREL;
				else if (scan_idx_q == NOTE_LAST)
					state_d = S_SFIN;
			end
			S_SREL: state_d = S_SPUSH;
			S_SPUSH: begin
				// previous freed voice goes out, not the last one
				if (!pend_q || out_free) begin
					out_load    = pend_q;
					out_found_d = 1'b1;
					out_last_d  = 1'b0;
					state_d     = (scan_idx_q == NOTE_LAST) ? S_SFIN : S_SCAN;
				end
			end
			S_SFIN: begin
				if (!pend_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					out_load    = 1'b1;
					out_found_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sustain_q    <= 1'b0;
			active_q     <= ACTIVE_RST;
			next_voice_q <= VW'(ACTIVE_RST - CFG_W'(1));
			nv_valid_q   <= '0;
			held_q       <= '0;
			vn_valid_q   <= '0;
			pend_q       <= 1'b0;
			scan_idx_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (cfg_wen) begin
				active_q     <= clamp_count(cfg_wdata);
				next_voice_q <= VW'(clamp_count(cfg_wdata) - CFG_W'(1));
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept && req_type == REQ_SUS_ON)
						sustain_q <= 1'b1;
					if (accept && req_type == REQ_SUS_OFF) begin
						sustain_q  <= 1'b0;
						scan_idx_q <= '0;
						pend_q     <= 1'b0;
					end
				end
				S_DEC: begin
					if (dec_miss) begin
						held_q[note_q] <= 1'b1;
						next_voice_q   <= (next_voice_q == '0) ?
							VW'(active_q - CFG_W'(1)) : next_voice_q - VW'(1);
					end
					if (req_q == REQ_NOTE_OFF)
						held_q[note_q] <= 1'b0;
					if (off_rel) begin
						nv_valid_q[note_q]  <= 1'b0;
						vn_valid_q[nv_rd_q] <= 1'b0;
					end
				end
				S_STEAL: begin
					// drop the note that owned the stolen voice, then map the new one
					if (vn_valid_q[v_q])
						nv_valid_q[vn_rd_q] <= 1'b0;
					vn_valid_q[v_q]    <= 1'b1;
					nv_valid_q[note_q] <= 1'b1;
				end
				S_SCAN: begin
					if (!scan_hit && scan_idx_q != NOTE_LAST)
						scan_idx_q <= scan_idx_q + NOTE_W'(1);
				end
				S_SREL: begin
					nv_valid_q[scan_idx_q] <= 1'b0;
					vn_valid_q[nv_rd_q]    <= 1'b0;
				end
				S_SPUSH: begin
					if (!pend_q || out_free) begin
						pend_q <= 1'b1;
						if (scan_idx_q != NOTE_LAST)
							scan_idx_q <= scan_idx_q + NOTE_W'(1);
					end
				end
				S_SFIN: begin
					if (!pend_q || out_free)
						pend_q <= 1'b0;
				end
				S_EMIT: ;
				default: ;
			endcase
		end
	end

	// payload registers and tables
	always_ff @(posedge clk) begin
		nv_rd_q <= nv_mem[nv_raddr];
		vn_rd_q <= vn_mem[next_voice_q];

		if (accept) begin
			note_q <= note;
			req_q  <= req_type;
		end

		if (state_q == S_DEC) begin
			v_q <= next_voice_q;
			if (req_q == REQ_NOTE_ON) begin
				res_voice_q <= nv_rd_q;
				res_found_q <= 1'b1;
			end else if (off_rel) begin
				res_voice_q <= nv_rd_q;
				res_found_q <= 1'b1;
			end else begin
				res_voice_q <= '0;
				res_found_q <= 1'b0;
			end
		end

		if (state_q == S_STEAL) begin
			nv_mem[note_q] <= v_q;
			vn_mem[v_q]    <= note_q;
			res_voice_q    <= v_q;
			res_found_q    <= 1'b1;
		end

		if (state_q == S_SREL)
			cur_q <= nv_rd_q;

		if (state_q == S_SPUSH && (!pend_q || out_free)) begin
			res_voice_q <= cur_q;
			res_found_q <= 1'b1;
		end

		if (out_load) begin
			out_voice_q <= VOICE_W'(out_voice_d);
			out_found_q <= out_found_d;
			out_last_q  <= out_last_d;
		end
	end

	// the pointer always stays inside the active voice range
	`ASSERT_IMPL(a_ptr_range, clk, arst_n, 1'b1, int'(next_voice_q) < int'(active_q))
	// a result is loaded only when the output register can take it
	`ASSERT_IMPL(a_no_overwrite, clk, arst_n, out_load, !out_valid_q || !out_stall)
	// release scan runs only with sustain off
	`ASSERT_IMPL(a_scan_sus, clk, arst_n, state_q == S_SCAN || state_q == S_SREL, !sustain_q)
	// a stolen voice ends up mapped
	`ASSERT_NEXT(a_steal_map, clk, arst_n, state_q == S_STEAL, vn_valid_q[v_q])

endmodule

### bench/tb.sv
// Self-checking bench for polyphonic_voice_allocator: directed and random MIDI event traffic.
// Depends on pva_pkg and the RTL; results are predicted in-bench and checked beat by beat.
module tb;
	import pva_pkg::*;

	localparam int VOICES = 16;
	// Sustain off with nothing to free keeps the sequencer busy for a full note-map walk
	// without a single output beat, so idle waits cover that.
	localparam int IDLE_PAUSE = 160;
	// Worst quiet stretch: idle pause plus sender gap, or a full scan with stalled beats.
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [VOICE_W-1:0] voice;
		logic               found;
		logic               last;
	} voice_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [REQ_W-1:0]   req_type = REQ_SUS_ON;
	logic [NOTE_W-1:0]  note = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [VOICE_W-1:0] voice;
	logic               found;
	logic               last;
	logic               cfg_wen = 1'b0;
	logic [CFG_W-1:0]   cfg_wdata = CFG_W'(VOICES);

	polyphonic_voice_allocator #(.MAX_VOICES(VOICES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.note      (note),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.voice     (voice),
		.found     (found),
		.last      (last),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Allocator mirror: note->voice and voice->note tables, held marks,
	// sustain pedal, round-robin pointer and the raw voice-count register.
	// ------------------------------------------------------------------
	bit                 note_live [NOTE_COUNT];
	logic [VOICE_W-1:0] note_voice [NOTE_COUNT];
	bit                 voice_live [VOICES];
	logic [NOTE_W-1:0]  voice_note [VOICES];
	bit                 note_held [NOTE_COUNT];
	bit                 sustain;
	int                 rr_next = VOICES - 1;
	int                 voices_reg = VOICES;

	voice_result_t voice_due_q[$];   // expected beats, oldest first
	int            err_count = 0;
	bit            quiet = 1'b0;     // no idling on either side while set
	logic [NOTE_W-1:0] note_pool[$]; // recently struck notes, to hit mapped entries

	// Register value clamped to the usable range: 0 acts as 1, above VOICES as VOICES.
	function automatic int active_voices();
		if (voices_reg < 1)
			return 1;
		if (voices_reg > VOICES)
			return VOICES;
		return voices_reg;
	endfunction

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	// Frees a mapped note and returns the voice it had.
	function automatic logic [VOICE_W-1:0] free_note(input int key);
		logic [VOICE_W-1:0] v;
		v = note_voice[key];
		note_live[key] = 1'b0;
		voice_live[v] = 1'b0;
		return v;
	endfunction

	// Update the mirror for one accepted event and queue the beats it causes.
	task automatic track_event(input logic [REQ_W-1:0] kind, input logic [NOTE_W-1:0] key);
		int cnt;
		int v;
		voice_result_t freed[$];
		cnt = active_voices();
		case (kind)
			REQ_NOTE_ON: begin
				if (note_live[key]) begin
					// retrigger: same voice, pointer and held mark untouched
					voice_due_q.push_back('{note_voice[key], 1'b1, 1'b1});
				end else begin
					note_held[key] = 1'b1;
					v = rr_next % cnt;
					rr_next = (v == 0) ? cnt - 1 : v - 1;
					// steal: whatever note sat on this voice loses it
					if (voice_live[v])
						note_live[voice_note[v]] = 1'b0;
					voice_live[v] = 1'b1;
					voice_note[v] = key;
					note_live[key] = 1'b1;
					note_voice[key] = VOICE_W'(v);
					voice_due_q.push_back('{VOICE_W'(v), 1'b1, 1'b1});
				end
			end
			REQ_NOTE_OFF: begin
				note_held[key] = 1'b0;
				if (!sustain && note_live[key])
					voice_due_q.push_back('{free_note(key), 1'b1, 1'b1});
				else
					voice_due_q.push_back('{VOICE_W'(0), 1'b0, 1'b1});
			end
			REQ_SUS_ON: begin
				sustain = 1'b1;
			end
			default: begin
				// pedal up: free every mapped, released note in ascending order
				sustain = 1'b0;
				for (int i = 0; i < NOTE_COUNT; i++) begin
					if (note_live[i] && !note_held[i] && freed.size() < VOICES)
						freed.push_back('{free_note(i), 1'b1, 1'b0});
				end
				foreach (freed[k]) begin
					freed[k].last = (k == freed.size() - 1);
					voice_due_q.push_back(freed[k]);
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Sender: one beat per call. Valid is left high after acceptance so a
	// zero gap gives back-to-back beats; it drops for a gap or a results wait.
	// ------------------------------------------------------------------
	task automatic send_event(input logic [REQ_W-1:0] kind, input logic [NOTE_W-1:0] key);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		note <= key;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_event(kind, key);
	endtask

	// Sender pauses until every expected beat has been seen.
	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (voice_due_q.size() != 0)
			@(posedge clk);
	endtask

	// Voice-count write, only with the block idle. A trailing sustain off may still be
	// walking the note map without output, hence the pause before the write.
	task automatic set_voices(input logic [CFG_W-1:0] value);
		wait_results_done();
		repeat (IDLE_PAUSE) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		voices_reg = value;
		rr_next = active_voices() - 1;
		cfg_wen <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver: checks each accepted beat against the oldest expectation and
	// draws a stall length after every beat; also stalls at random while idle.
	// ------------------------------------------------------------------
	int hold_left = 0;

	always @(posedge clk) begin
		voice_result_t got;
		voice_result_t want;
		if (!arst_n) begin
			hold_left = 0;
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{voice, found, last};
				if (voice_due_q.size() == 0) begin
					if (err_count < 10)
						$display("%0t: unexpected beat voice=%0d found=%0b last=%0b",
							$time, got.voice, got.found, got.last);
					err_count++;
				end else begin
					want = voice_due_q.pop_front();
					if (got.voice !== want.voice || got.found !== want.found
							|| got.last !== want.last) begin
						if (err_count < 10)
							$display({"%0t: mismatch expected voice=%0d found=%0b last=%0b",
								" got voice=%0d found=%0b last=%0b"}, $time,
								want.voice, want.found, want.last,
								got.voice, got.found, got.last);
						err_count++;
					end
				end
				hold_left = draw_wait();
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 10);
			end
			out_stall <= (hold_left > 0);
		end
	end

	// Watchdog: any accepted beat on either side restarts the count.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: watchdog expired, %0d beats outstanding", $time, voice_due_q.size());
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hits, releases, no-op note off, sustain hold and pedal up with and without work.
	task automatic test_note_basics();
		send_event(REQ_NOTE_ON, 7'd0);
		send_event(REQ_NOTE_ON, 7'd127);
		send_event(REQ_NOTE_ON, 7'd0);      // retrigger of a mapped note
		send_event(REQ_NOTE_OFF, 7'd127);
		send_event(REQ_NOTE_OFF, 7'd127);   // already free
		send_event(REQ_NOTE_OFF, 7'h55);    // never mapped
		send_event(REQ_SUS_ON, 7'h2A);
		send_event(REQ_NOTE_ON, 7'h2A);
		send_event(REQ_NOTE_OFF, 7'h2A);    // pedal down: nothing freed
		send_event(REQ_SUS_OFF, 7'h7F);     // frees 0x2A, note 0 still held
		send_event(REQ_SUS_OFF, 7'h00);     // nothing left to free
		send_event(REQ_NOTE_OFF, 7'd0);
	endtask

	// Voice-count register: single voice stealing, out-of-range values, shrinking
	// while a voice above the new count is still in use.
	task automatic test_voice_count();
		set_voices(5'd1);
		send_event(REQ_NOTE_ON, 7'd10);
		send_event(REQ_NOTE_ON, 7'd11);     // steals voice 0 from note 10
		send_event(REQ_NOTE_OFF, 7'd10);
		send_event(REQ_NOTE_OFF, 7'd11);
		set_voices(5'd0);                   // acts as one voice
		send_event(REQ_NOTE_ON, 7'd20);
		set_voices(5'd31);                  // clamps to the full count
		send_event(REQ_NOTE_ON, 7'd21);
		set_voices(5'd2);
		send_event(REQ_NOTE_ON, 7'd22);
		send_event(REQ_NOTE_OFF, 7'd21);    // voice above the count is still freed
		send_event(REQ_NOTE_OFF, 7'd20);
		send_event(REQ_NOTE_OFF, 7'd22);
	endtask

	// Full chord under the pedal, then pedal up frees every voice in one burst.
	task automatic test_sustain_chord();
		int base;
		base = $urandom_range(0, NOTE_COUNT - VOICES);
		set_voices(CFG_W'(VOICES));
		send_event(REQ_SUS_ON, 7'($urandom_range(0, 127)));
		for (int k = 0; k < VOICES; k++)
			send_event(REQ_NOTE_ON, NOTE_W'(base + k));
		for (int k = VOICES - 1; k >= 0; k--)
			send_event(REQ_NOTE_OFF, NOTE_W'(base + k));
		send_event(REQ_SUS_OFF, 7'($urandom_range(0, 127)));
	endtask

	// One random event; keys favor recently struck notes so offs and hits land.
	task automatic random_event();
		int pick;
		logic [NOTE_W-1:0] key;
		pick = $urandom_range(0, 99);
		if (note_pool.size() != 0 && $urandom_range(0, 1))
			key = note_pool[$urandom_range(0, note_pool.size() - 1)];
		else
			key = NOTE_W'($urandom_range(0, 127));
		if (pick < 45) begin
			send_event(REQ_NOTE_ON, key);
			note_pool.push_back(key);
			if (note_pool.size() > 24)
				void'(note_pool.pop_front());
		end else if (pick < 80) begin
			send_event(REQ_NOTE_OFF, key);
		end else if (pick < 90) begin
			send_event(REQ_SUS_ON, key);
		end else begin
			send_event(REQ_SUS_OFF, key);
		end
	endtask

	// Random traffic over several voice counts, with and without idling.
	task automatic test_random_traffic();
		logic [CFG_W-1:0] phase_cfg [4];
		phase_cfg[0] = CFG_W'(VOICES);
		phase_cfg[1] = CFG_W'($urandom_range(1, VOICES - 1));
		phase_cfg[2] = CFG_W'($urandom_range(0, 31));
		phase_cfg[3] = CFG_W'($urandom_range(1, 4));
		foreach (phase_cfg[p]) begin
			set_voices(phase_cfg[p]);
			quiet = (p == 1);
			for (int i = 0; i < 28; i++) begin
				if (p != 1 && $urandom_range(0, 15) == 0)
					quiet = !quiet;
				random_event();
			end
			quiet = 1'b0;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_note_basics();
		test_voice_count();
		test_sustain_chord();
		test_random_traffic();
		wait_results_done();
		repeat (IDLE_PAUSE) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/pva_pkg.sv
hw/rtl/polyphonic_voice_allocator.sv
bench/tb.sv
